// ===== hw/rtl/r2h_pkg.sv =====
// Shared constants and types for the RGB to HSV converter.
// No dependencies; imported by every module of the block.
package r2h_pkg;

  // Default channel width of the pixel inputs
  localparam int unsigned CHANNEL_BITS_DEFAULT = 8;

  // Width of the hue field and of every byte-wide output field
  localparam int unsigned HUE_QBITS = 15;
  localparam int unsigned OUT_BITS  = 8;

  // Hue scale: 60 degrees and a full turn in 1/64 degree units
  localparam int unsigned SIXTY_DEG = 3840;
  localparam int unsigned FULL_TURN = 23040;

  // Per-pixel control flags carried along the divider chain
  typedef struct packed {
    logic hue_zero;  // grey pixel: hue forced to 0
    logic hue_neg;   // red sector with green below blue: wrap the angle
    logic sat_zero;  // black pixel: saturation forced to 0
  } r2h_flags_t;

endpackage

// ===== hw/rtl/r2h_prep.sv =====
// Front cell of the converter: max/min search, sector select, dividends.
// Depends on r2h_pkg.
module r2h_prep import r2h_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [CHANNEL_BITS-1:0]     red,
  input  logic [CHANNEL_BITS-1:0]     green,
  input  logic [CHANNEL_BITS-1:0]     blue,
  input  logic [OUT_BITS-1:0]         alpha,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [CHANNEL_BITS+((CHANNEL_BITS > HUE_QBITS) ? CHANNEL_BITS : HUE_QBITS)-1:0] hue_acc,
  output logic [CHANNEL_BITS+((CHANNEL_BITS > HUE_QBITS) ? CHANNEL_BITS : HUE_QBITS)-1:0] sat_acc,
  output logic [CHANNEL_BITS-1:0]     hue_div,
  output logic [CHANNEL_BITS-1:0]     sat_div,
  output logic [CHANNEL_BITS-1:0]     bright,
  output logic [OUT_BITS-1:0]         opacity,
  output r2h_flags_t                  flags
);

  localparam int unsigned STEPS = (CHANNEL_BITS > HUE_QBITS) ? CHANNEL_BITS : HUE_QBITS;
  localparam int unsigned AW    = CHANNEL_BITS + STEPS;
  localparam int unsigned NW    = CHANNEL_BITS + 3;

  logic [CHANNEL_BITS-1:0] mx, mn, d;
  logic                    red_max, green_max, neg;
  logic [NW-1:0]           r_w, g_w, b_w, d_w, num;
  logic [AW-1:0]           hue_acc_next, sat_acc_next;
  r2h_flags_t              flags_next;

  // Find the largest and smallest channel
  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d = mx - mn;
  end

  // Pick the sector numerator, priority red, then green, then blue
  always_comb begin
    r_w       = NW'(red);
    g_w       = NW'(green);
    b_w       = NW'(blue);
    d_w       = NW'(d);
    red_max   = (mx == red);
    green_max = (mx == green);
    neg       = 1'b0;
    if (red_max) begin
      if (green >= blue) begin
        num = g_w - b_w;
      end else begin
        num = b_w - g_w;
        neg = 1'b1;
      end
    end else if (green_max) begin
      num = (d_w << 1) + b_w - r_w;
    end else begin
      num = (d_w << 2) + r_w - g_w;
    end
  end

  // Form the dividends: 60 degrees times numerator, and spread times full scale
  always_comb begin
    hue_acc_next        = AW'(num) * AW'(SIXTY_DEG);
    sat_acc_next        = AW'({d, {CHANNEL_BITS{1'b0}}}) - AW'(d);
    flags_next.hue_zero = (d == '0);
    flags_next.hue_neg  = neg;
    flags_next.sat_zero = (mx == '0);
  end

  assign in_ready = !out_valid || out_ready;

  // Hold the stage while downstream stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hue_acc <= hue_acc_next;
      sat_acc <= sat_acc_next;
      hue_div <= d;
      sat_div <= mx;
      bright  <= mx;
      opacity <= alpha;
      flags   <= flags_next;
    end
  end

endmodule

// ===== hw/rtl/r2h_div_cell.sv =====
// One cell of the divider chain: a restoring step for hue and saturation.
// Depends on r2h_pkg.
module r2h_div_cell import r2h_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [CHANNEL_BITS+((CHANNEL_BITS > HUE_QBITS) ? CHANNEL_BITS : HUE_QBITS)-1:0] in_hue_acc,
  input  logic [CHANNEL_BITS+((CHANNEL_BITS > HUE_QBITS) ? CHANNEL_BITS : HUE_QBITS)-1:0] in_sat_acc,
  input  logic [CHANNEL_BITS-1:0]     in_hue_div,
  input  logic [CHANNEL_BITS-1:0]     in_sat_div,
  input  logic [CHANNEL_BITS-1:0]     in_bright,
  input  logic [OUT_BITS-1:0]         in_opacity,
  input  r2h_flags_t                  in_flags,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [CHANNEL_BITS+((CHANNEL_BITS > HUE_QBITS) ? CHANNEL_BITS : HUE_QBITS)-1:0] hue_acc,
  output logic [CHANNEL_BITS+((CHANNEL_BITS > HUE_QBITS) ? CHANNEL_BITS : HUE_QBITS)-1:0] sat_acc,
  output logic [CHANNEL_BITS-1:0]     hue_div,
  output logic [CHANNEL_BITS-1:0]     sat_div,
  output logic [CHANNEL_BITS-1:0]     bright,
  output logic [OUT_BITS-1:0]         opacity,
  output r2h_flags_t                  flags
);

  localparam int unsigned STEPS = (CHANNEL_BITS > HUE_QBITS) ? CHANNEL_BITS : HUE_QBITS;
  localparam int unsigned AW    = CHANNEL_BITS + STEPS;

  logic [CHANNEL_BITS:0]   h_trial, s_trial, h_diff, s_diff;
  logic                    h_ge, s_ge;
  logic [CHANNEL_BITS-1:0] h_rem, s_rem;
  logic [AW-1:0]           hue_acc_next, sat_acc_next;

  // Shift in the next dividend bit, trial subtract, restore on borrow
  always_comb begin
    h_trial      = {in_hue_acc[AW-1:STEPS], in_hue_acc[STEPS-1]};
    s_trial      = {in_sat_acc[AW-1:STEPS], in_sat_acc[STEPS-1]};
    h_diff       = h_trial - {1'b0, in_hue_div};
    s_diff       = s_trial - {1'b0, in_sat_div};
    h_ge         = (h_trial >= {1'b0, in_hue_div});
    s_ge         = (s_trial >= {1'b0, in_sat_div});
    h_rem        = h_ge ? h_diff[CHANNEL_BITS-1:0] : h_trial[CHANNEL_BITS-1:0];
    s_rem        = s_ge ? s_diff[CHANNEL_BITS-1:0] : s_trial[CHANNEL_BITS-1:0];
    hue_acc_next = {h_rem, in_hue_acc[STEPS-2:0], h_ge};
    sat_acc_next = {s_rem, in_sat_acc[STEPS-2:0], s_ge};
  end

  assign in_ready = !out_valid || out_ready;

  // Advance when the next cell has room
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hue_acc <= hue_acc_next;
      sat_acc <= sat_acc_next;
      hue_div <= in_hue_div;
      sat_div <= in_sat_div;
      bright  <= in_bright;
      opacity <= in_opacity;
      flags   <= in_flags;
    end
  end

  // Partial remainders stay below a nonzero divisor
  a_hue_rem: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hue_div != '0) |-> (hue_acc[AW-1:STEPS] < hue_div))
    else $error("hue partial remainder not below divisor");

  a_sat_rem: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sat_div != '0) |-> (sat_acc[AW-1:STEPS] < sat_div))
    else $error("saturation partial remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("cell dropped a stalled transaction");

endmodule

// ===== hw/rtl/rgb_to_hsv_converter.sv =====
// Top level of the RGB to HSV converter: front cell, divider chain, output stage.
// Depends on r2h_pkg, r2h_prep and r2h_div_cell.
//
// Converts one RGBA pixel per clock into hue, saturation, brightness and
// opacity while result_ready does not stall it. The block is a pipeline of
// cells: one front cell that finds max, min and the hue sector, then a chain of
// max(15, CHANNEL_BITS) divider cells that each retire one quotient bit for
// hue and saturation at once, then an output register that applies the hue
// wrap. A new pixel is taken every cycle unless the output stalls. Every stage
// has its own valid bit and accepts data when it is empty or moving on, so
// bubbles close up; pixel_ready drops only when every stage holds a pixel and
// result_ready is low.
module rgb_to_hsv_converter import r2h_pkg::*; #(
  parameter int unsigned CHANNEL_BITS = CHANNEL_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    pixel_valid,
  output logic                    pixel_ready,
  input  logic [CHANNEL_BITS-1:0] red,
  input  logic [CHANNEL_BITS-1:0] green,
  input  logic [CHANNEL_BITS-1:0] blue,
  input  logic [OUT_BITS-1:0]     alpha,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic [HUE_QBITS-1:0]    hue,
  output logic [OUT_BITS-1:0]     saturation,
  output logic [OUT_BITS-1:0]     brightness,
  output logic [OUT_BITS-1:0]     opacity
);

  localparam int unsigned STEPS = (CHANNEL_BITS > HUE_QBITS) ? CHANNEL_BITS : HUE_QBITS;
  localparam int unsigned AW    = CHANNEL_BITS + STEPS;
  localparam int unsigned EW    = (CHANNEL_BITS > OUT_BITS) ? CHANNEL_BITS : OUT_BITS;

  // Chain taps: index 0 is the front cell, index STEPS the last divider cell
  logic                    valid   [STEPS+1];
  logic                    ready   [STEPS+1];
  logic [AW-1:0]           hue_acc [STEPS+1];
  logic [AW-1:0]           sat_acc [STEPS+1];
  logic [CHANNEL_BITS-1:0] hue_div [STEPS+1];
  logic [CHANNEL_BITS-1:0] sat_div [STEPS+1];
  logic [CHANNEL_BITS-1:0] bright  [STEPS+1];
  logic [OUT_BITS-1:0]     opac    [STEPS+1];
  r2h_flags_t              flags   [STEPS+1];

  logic                    out_ready;
  logic [HUE_QBITS-1:0]    q_hue, hue_next;
  logic [EW-1:0]           sat_ext, bright_ext;

  r2h_prep #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixel_valid),
    .in_ready (pixel_ready),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .alpha    (alpha),
    .out_valid(valid[0]),
    .out_ready(ready[0]),
    .hue_acc  (hue_acc[0]),
    .sat_acc  (sat_acc[0]),
    .hue_div  (hue_div[0]),
    .sat_div  (sat_div[0]),
    .bright   (bright[0]),
    .opacity  (opac[0]),
    .flags    (flags[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    r2h_div_cell #(
      .CHANNEL_BITS(CHANNEL_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[i]),
      .in_ready  (ready[i]),
      .in_hue_acc(hue_acc[i]),
      .in_sat_acc(sat_acc[i]),
      .in_hue_div(hue_div[i]),
      .in_sat_div(sat_div[i]),
      .in_bright (bright[i]),
      .in_opacity(opac[i]),
      .in_flags  (flags[i]),
      .out_valid (valid[i+1]),
      .out_ready (ready[i+1]),
      .hue_acc   (hue_acc[i+1]),
      .sat_acc   (sat_acc[i+1]),
      .hue_div   (hue_div[i+1]),
      .sat_div   (sat_div[i+1]),
      .bright    (bright[i+1]),
      .opacity   (opac[i+1]),
      .flags     (flags[i+1])
    );
  end

  // Apply the grey and black overrides and the red-sector wrap, fit the byte fields
  always_comb begin
    q_hue = hue_acc[STEPS][HUE_QBITS-1:0];
    if (flags[STEPS].hue_zero) begin
      hue_next = '0;
    end else if (flags[STEPS].hue_neg && q_hue != '0) begin
      hue_next = HUE_QBITS'(FULL_TURN) - q_hue;
    end else begin
      hue_next = q_hue;
    end
    sat_ext    = flags[STEPS].sat_zero ? '0 : EW'(sat_acc[STEPS][CHANNEL_BITS-1:0]);
    bright_ext = EW'(bright[STEPS]);
  end

  assign out_ready    = !result_valid || result_ready;
  assign ready[STEPS] = out_ready;

  // Hold the result until the consumer takes the transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= valid[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && valid[STEPS]) begin
      hue        <= hue_next;
      saturation <= sat_ext[OUT_BITS-1:0];
      brightness <= bright_ext[OUT_BITS-1:0];
      opacity    <= opac[STEPS];
    end
  end

  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (hue < HUE_QBITS'(FULL_TURN)))
    else $error("hue beyond a full turn");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> (result_valid && !result_ready))
    else $error("input stalled while output is free");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(valid[STEPS]))
    else $error("result appeared without a transaction in the last cell");

endmodule

// ===== bench/tb_rgb_to_hsv_converter.sv =====
// Self-checking testbench for the RGB to HSV converter top level.
// Depends on r2h_pkg and rgb_to_hsv_converter; runs directed and random pixels
// under varied handshake pressure and checks every result against a predictor.
import r2h_pkg::*;

typedef struct {
  logic [HUE_QBITS-1:0] hue;
  logic [OUT_BITS-1:0]  saturation;
  logic [OUT_BITS-1:0]  brightness;
  logic [OUT_BITS-1:0]  opacity;
} hsv_pixel_t;

// Predict the HSV result of each accepted pixel and match results in order
class hsv_scoreboard;
  hsv_pixel_t expected_q[$];
  int         errors;

  function new();
    errors = 0;
  endfunction

  // Convert one pixel the way the block should
  function hsv_pixel_t convert(int unsigned r, int unsigned g, int unsigned b,
                               int unsigned a);
    hsv_pixel_t  px;
    int unsigned mx;
    int unsigned mn;
    int unsigned d;
    int unsigned q;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // Saturation: spread over max, truncated; black gives zero
    px.saturation = (mx == 0) ? '0 : OUT_BITS'((d * 255) / mx);
    px.brightness = OUT_BITS'(mx);
    px.opacity    = OUT_BITS'(a);
    // Hue: sector of the largest channel, red wins ties, then green
    if (d == 0) begin
      q = 0;
    end else if (mx == r) begin
      if (g >= b) begin
        q = (SIXTY_DEG * (g - b)) / d;
      end else begin
        q = (SIXTY_DEG * (b - g)) / d;
        q = (q == 0) ? 0 : FULL_TURN - q;
      end
    end else if (mx == g) begin
      q = (SIXTY_DEG * (2 * d + b - r)) / d;
    end else begin
      q = (SIXTY_DEG * (4 * d + r - g)) / d;
    end
    px.hue = HUE_QBITS'(q);
    return px;
  endfunction

  // Queue the expected result of an accepted pixel at the tail
  function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
    expected_q.insert(expected_q.size(), convert(32'(r), 32'(g), 32'(b), 32'(a)));
  endfunction

  function void check_result(hsv_pixel_t got);
    hsv_pixel_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result with no pixel pending: hue=%0d sat=%0d val=%0d alpha=%0d",
               $time, got.hue, got.saturation, got.brightness, got.opacity);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.hue !== want.hue) begin
      $display("%0t: hue mismatch: expected %0d, actual %0d", $time, want.hue, got.hue);
      errors++;
    end
    if (got.saturation !== want.saturation) begin
      $display("%0t: saturation mismatch: expected %0d, actual %0d",
               $time, want.saturation, got.saturation);
      errors++;
    end
    if (got.brightness !== want.brightness) begin
      $display("%0t: brightness mismatch: expected %0d, actual %0d",
               $time, want.brightness, got.brightness);
      errors++;
    end
    if (got.opacity !== want.opacity) begin
      $display("%0t: opacity mismatch: expected %0d, actual %0d",
               $time, want.opacity, got.opacity);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_rgb_to_hsv_converter;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 280;
  localparam int unsigned HOLD_CYCLES = 80;

  logic                 clk;
  logic                 rst;
  logic                 pixel_valid;
  logic                 pixel_ready;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;
  logic [7:0]           alpha;
  logic                 result_valid;
  logic                 result_ready;
  logic [HUE_QBITS-1:0] hue;
  logic [OUT_BITS-1:0]  saturation;
  logic [OUT_BITS-1:0]  brightness;
  logic [OUT_BITS-1:0]  opacity;

  hsv_scoreboard hsv_sb;
  int unsigned   send_idle_pct;
  int unsigned   recv_stall_pct;
  logic          hold_results;
  int unsigned   cycles;

  rgb_to_hsv_converter uut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .alpha        (alpha),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .hue          (hue),
    .saturation   (saturation),
    .brightness   (brightness),
    .opacity      (opacity)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Drive result_ready at random, or hold it low during a long stall
  initial begin
    forever begin
      @(negedge clk);
      result_ready = !hold_results && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    hsv_pixel_t got;
    if (!rst && result_valid && result_ready) begin
      got.hue        = hue;
      got.saturation = saturation;
      got.brightness = brightness;
      got.opacity    = opacity;
      hsv_sb.check_result(got);
    end
  end

  // Offer one pixel, starting and ending at a falling edge
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid = 1'b0;
      @(negedge clk);
    end
    pixel_valid = 1'b1;
    red   = r;
    green = g;
    blue  = b;
    alpha = a;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    hsv_sb.note_pixel(r, g, b, a);
    @(negedge clk);
  endtask

  function automatic logic [7:0] edge_value();
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // Random pixel, biased toward grey, ties and extreme channels
  task automatic send_random_pixel();
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] v;
    r = 8'($urandom);
    g = 8'($urandom);
    b = 8'($urandom);
    v = 8'($urandom);
    case ($urandom_range(9))
      0: begin
        g = r;
        b = r;
      end
      1: begin
        case ($urandom_range(2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      2: begin
        r = edge_value();
        g = edge_value();
        b = edge_value();
      end
      3: begin
        // near-grey: one channel a step away from the others
        g = r;
        b = ($urandom_range(1) != 0) ? r + 8'd1 : r - 8'd1;
      end
      default: ;
    endcase
    send_pixel(r, g, b, v);
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_random_pixel();
  endtask

  // Stall the output for a fixed stretch while pixels keep coming
  task automatic hold_output();
    hold_results = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    @(negedge clk);
    hold_results = 1'b0;
  endtask

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    pixel_valid    = 1'b0;
    red            = '0;
    green          = '0;
    blue           = '0;
    alpha          = '0;
    result_ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_results   = 1'b0;
    cycles         = 0;
    hsv_sb         = new();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: black, white, grey, primaries, ties and wrap cases
    send_pixel(8'd0,   8'd0,   8'd0,   8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128, 8'h55);
    send_pixel(8'd255, 8'd0,   8'd0,   8'hAA);
    send_pixel(8'd0,   8'd255, 8'd0,   8'h0F);
    send_pixel(8'd0,   8'd0,   8'd255, 8'hF0);
    send_pixel(8'd255, 8'd255, 8'd0,   8'd1);
    send_pixel(8'd0,   8'd255, 8'd255, 8'd254);
    send_pixel(8'd255, 8'd0,   8'd255, 8'd128);
    send_pixel(8'd255, 8'd254, 8'd255, 8'd127);
    send_pixel(8'd255, 8'd0,   8'd1,   8'd0);
    send_pixel(8'd255, 8'd1,   8'd0,   8'd255);
    send_pixel(8'd1,   8'd0,   8'd0,   8'd3);
    send_pixel(8'd1,   8'd1,   8'd0,   8'd7);
    send_pixel(8'd0,   8'd1,   8'd1,   8'd9);
    send_pixel(8'd1,   8'd0,   8'd1,   8'd11);
    send_pixel(8'd254, 8'd255, 8'd253, 8'd13);
    send_pixel(8'd100, 8'd50,  8'd200, 8'd17);
    send_pixel(8'd10,  8'd200, 8'd30,  8'd19);
    send_pixel(8'd200, 8'd10,  8'd30,  8'd23);
    send_pixel(8'd1,   8'd1,   8'd1,   8'd29);
    send_pixel(8'd255, 8'd255, 8'd254, 8'd31);

    // Random pixels under each handshake profile
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 88;
    run_random(ITEMS_PER_PHASE);
    send_idle_pct  = 0;
    recv_stall_pct = 88;
    run_random(ITEMS_PER_PHASE);
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    run_random(ITEMS_PER_PHASE);

    // Fill the pipeline against a held output
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      hold_output();
      run_random(40);
    join
    run_random(ITEMS_PER_PHASE);
    pixel_valid = 1'b0;

    // Drain outstanding results, then wait on to catch any stray result
    while (hsv_sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (hsv_sb.errors == 0 && hsv_sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
